/* rtl/cau_pkg.sv */
// Shared types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Quotient bits resolved by the divider; larger quotients always saturate.
  localparam int QB       = 33;
  localparam int RW       = 64 + QB;
  localparam int SQ_STEPS = 32;
  localparam int NSTEP    = QB;
  localparam int ANG_BITS = 30;
  localparam int ZW       = 34;
  localparam int XW       = 64;

  localparam logic signed [ZW-1:0] PI_HALF = 34'sd1686629713;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_MAG   = 3'd4,
    CMD_PHASE = 3'd5,
    CMD_EQ    = 3'd6
  } cmd_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Word as it travels through the iterative stages.
  typedef struct packed {
    logic                 vld;
    logic [2:0]           cmd;
    logic [31:0]          e_re;
    logic [31:0]          e_im;
    logic                 e_sat;
    logic                 eq;
    logic [63:0]          den;
    logic                 dre_neg;
    logic                 dim_neg;
    logic                 dre_ovf;
    logic                 dim_ovf;
    logic [RW-1:0]        dre_r;
    logic [RW-1:0]        dim_r;
    logic [QB-1:0]        dre_q;
    logic [QB-1:0]        dim_q;
    logic [63:0]          sq_n;
    logic [63:0]          sq_r;
    logic signed [XW-1:0] cx;
    logic signed [XW-1:0] cy;
    logic signed [ZW-1:0] cz;
    logic                 pzero;
  } step_t;

  // Arctangent of 2^-i with 30 fractional bits.
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      10:      a = 34'sd1048576;
      default: a = ZW'(1) << (ANG_BITS - i);
    endcase
    return a;
  endfunction

  // Clamp a signed value to 32 bits; returns {saturated, value}.
  function automatic logic [32:0] sat_s34(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -34'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Clamp a sign and magnitude pair to 32 bits; returns {saturated, value}.
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
    logic [32:0] r;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, -mag[31:0]};
      end
    end else begin
      if (mag > 64'h7FFF_FFFF) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, mag[31:0]};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/cau_step.sv */
// Iterative stage: a quotient bit; early ones add a square-root digit and a CORDIC step.
module cau_step #(
  parameter int J             = 0,
  parameter int CORDIC_STAGES = cau_pkg::CORDIC_STAGES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  cau_pkg::step_t d,
  output cau_pkg::step_t q
);
  import cau_pkg::*;

  localparam bit          DO_SQ  = (J < SQ_STEPS);
  localparam bit          DO_C   = (J < CORDIC_STAGES);
  localparam int          SQ_SH  = DO_SQ ? (62 - 2 * J) : 0;
  localparam logic [63:0] SQ_BIT = 64'd1 << SQ_SH;
  localparam logic signed [ZW-1:0] ANG = atan_q30(DO_C ? J : 0);

  step_t                nx;
  logic [RW-1:0]        dsh;
  logic [63:0]          sq_t;
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  always_comb begin
    nx   = d;
    dsh  = RW'(d.den) << (QB - 1 - J);
    sq_t = d.sq_r + SQ_BIT;
    xs   = d.cx >>> J;
    ys   = d.cy >>> J;

    if (d.dre_r >= dsh) begin
      nx.dre_r = d.dre_r - dsh;
      nx.dre_q[QB-1-J] = 1'b1;
    end
    if (d.dim_r >= dsh) begin
      nx.dim_r = d.dim_r - dsh;
      nx.dim_q[QB-1-J] = 1'b1;
    end

    if (DO_SQ) begin
      if (d.sq_n >= sq_t) begin
        nx.sq_n = d.sq_n - sq_t;
        nx.sq_r = (d.sq_r >> 1) + SQ_BIT;
      end else begin
        nx.sq_r = d.sq_r >> 1;
      end
    end

    if (DO_C) begin
      if (!d.cy[XW-1]) begin
        nx.cx = d.cx + ys;
        nx.cy = d.cy - xs;
        nx.cz = d.cz + ANG;
      end else begin
        nx.cx = d.cx - ys;
        nx.cy = d.cy + xs;
        nx.cz = d.cz - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= nx;
    end
  end

endmodule

/* rtl/complex_arithmetic_unit_top.sv */
// Top level of the pipelined complex arithmetic unit.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS     = cau_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = cau_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               is_equal,
  output logic [1:0]         status
);
  // This unit takes one word per clock whenever the pipeline advances and returns one
  // result word per input word, in order. Every command runs through the same
  // pipeline: a stage of 32x32 products, one of sums, one of magnitudes, one that
  // rounds products and sets up the divider, 33 restoring-division stages (one
  // quotient bit each, which also host the 32 square-root digits and the CORDIC
  // rotations), and one output register. The 33-stage quotient chain sets the
  // latency. The whole pipeline advances together whenever the output register is
  // empty or its word is taken, so a stall holds every stage in place and nothing is
  // dropped or repeated. Operands and results are signed Q15.16 by default; results
  // that leave the 32-bit range are clamped and flagged, and a zero divisor returns
  // zero with a divide-by-zero status. There is no stored state and no configuration.
  import cau_pkg::*;

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam logic signed [ZW-1:0] ZRND = ZW'((64'd1 << SH) >> 1);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage 1: products, add and subtract, equality, CORDIC pre-rotation.
  logic signed [32:0]   add_re, add_im, sub_re, sub_im;
  logic [32:0]          sr_re, sr_im;
  logic signed [XW-1:0] x0, y0, cx0, cy0;
  logic signed [ZW-1:0] cz0;

  assign add_re = {a_re[31], a_re} + {b_re[31], b_re};
  assign add_im = {a_im[31], a_im} + {b_im[31], b_im};
  assign sub_re = {a_re[31], a_re} - {b_re[31], b_re};
  assign sub_im = {a_im[31], a_im} - {b_im[31], b_im};
  assign sr_re  = (command == CMD_SUB) ? sat_s34(34'(sub_re)) : sat_s34(34'(add_re));
  assign sr_im  = (command == CMD_SUB) ? sat_s34(34'(sub_im)) : sat_s34(34'(add_im));
  assign x0     = {{(XW-61){a_re[31]}}, a_re, 29'd0};
  assign y0     = {{(XW-61){a_im[31]}}, a_im, 29'd0};

  // A point in the left half plane is turned a quarter turn toward the right half.
  always_comb begin
    cx0 = x0;
    cy0 = y0;
    cz0 = '0;
    if (a_re[31]) begin
      if (!a_im[31]) begin
        cx0 = y0;
        cy0 = -x0;
        cz0 = PI_HALF;
      end else begin
        cx0 = -y0;
        cy0 = x0;
        cz0 = -PI_HALF;
      end
    end
  end

  logic                 p1_vld;
  logic [2:0]           p1_cmd;
  logic signed [63:0]   p1_rr, p1_ii, p1_ri, p1_ir, p1_aa_r, p1_aa_i, p1_bb_r, p1_bb_i;
  logic [31:0]          p1_e_re, p1_e_im;
  logic                 p1_e_sat, p1_eq, p1_pz;
  logic signed [XW-1:0] p1_cx, p1_cy;
  logic signed [ZW-1:0] p1_cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (adv) begin
      p1_vld   <= in_valid;
      p1_cmd   <= command;
      p1_rr    <= a_re * b_re;
      p1_ii    <= a_im * b_im;
      p1_ri    <= a_re * b_im;
      p1_ir    <= a_im * b_re;
      p1_aa_r  <= a_re * a_re;
      p1_aa_i  <= a_im * a_im;
      p1_bb_r  <= b_re * b_re;
      p1_bb_i  <= b_im * b_im;
      p1_e_re  <= sr_re[31:0];
      p1_e_im  <= sr_im[31:0];
      p1_e_sat <= sr_re[32] | sr_im[32];
      p1_eq    <= (a_re == b_re) && (a_im == b_im);
      p1_cx    <= cx0;
      p1_cy    <= cy0;
      p1_cz    <= cz0;
      p1_pz    <= (a_re == 32'sd0) && (a_im == 32'sd0);
    end
  end

  // Stage 2: exact sums of product pairs.
  logic                 p2_vld;
  logic [2:0]           p2_cmd;
  logic signed [64:0]   p2_m_re, p2_m_im, p2_d_re, p2_d_im;
  logic [63:0]          p2_den, p2_sq;
  logic [31:0]          p2_e_re, p2_e_im;
  logic                 p2_e_sat, p2_eq, p2_pz;
  logic signed [XW-1:0] p2_cx, p2_cy;
  logic signed [ZW-1:0] p2_cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else if (adv) begin
      p2_vld   <= p1_vld;
      p2_cmd   <= p1_cmd;
      p2_m_re  <= {p1_rr[63], p1_rr} - {p1_ii[63], p1_ii};
      p2_m_im  <= {p1_ri[63], p1_ri} + {p1_ir[63], p1_ir};
      p2_d_re  <= {p1_rr[63], p1_rr} + {p1_ii[63], p1_ii};
      p2_d_im  <= {p1_ir[63], p1_ir} - {p1_ri[63], p1_ri};
      p2_den   <= p1_bb_r + p1_bb_i;
      p2_sq    <= p1_aa_r + p1_aa_i;
      p2_e_re  <= p1_e_re;
      p2_e_im  <= p1_e_im;
      p2_e_sat <= p1_e_sat;
      p2_eq    <= p1_eq;
      p2_cx    <= p1_cx;
      p2_cy    <= p1_cy;
      p2_cz    <= p1_cz;
      p2_pz    <= p1_pz;
    end
  end

  // Stage 3: sign and magnitude of each sum.
  logic                 p3_vld;
  logic [2:0]           p3_cmd;
  logic [63:0]          p3_mm_re, p3_mm_im, p3_dm_re, p3_dm_im;
  logic                 p3_mn_re, p3_mn_im, p3_dn_re, p3_dn_im;
  logic [63:0]          p3_den, p3_sq;
  logic [31:0]          p3_e_re, p3_e_im;
  logic                 p3_e_sat, p3_eq, p3_pz;
  logic signed [XW-1:0] p3_cx, p3_cy;
  logic signed [ZW-1:0] p3_cz;
  logic signed [64:0]   nm_re, nm_im, nd_re, nd_im;

  assign nm_re = -p2_m_re;
  assign nm_im = -p2_m_im;
  assign nd_re = -p2_d_re;
  assign nd_im = -p2_d_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else if (adv) begin
      p3_vld   <= p2_vld;
      p3_cmd   <= p2_cmd;
      p3_mn_re <= p2_m_re[64];
      p3_mn_im <= p2_m_im[64];
      p3_dn_re <= p2_d_re[64];
      p3_dn_im <= p2_d_im[64];
      p3_mm_re <= p2_m_re[64] ? nm_re[63:0] : p2_m_re[63:0];
      p3_mm_im <= p2_m_im[64] ? nm_im[63:0] : p2_m_im[63:0];
      p3_dm_re <= p2_d_re[64] ? nd_re[63:0] : p2_d_re[63:0];
      p3_dm_im <= p2_d_im[64] ? nd_im[63:0] : p2_d_im[63:0];
      p3_den   <= p2_den;
      p3_sq    <= p2_sq;
      p3_e_re  <= p2_e_re;
      p3_e_im  <= p2_e_im;
      p3_e_sat <= p2_e_sat;
      p3_eq    <= p2_eq;
      p3_cx    <= p2_cx;
      p3_cy    <= p2_cy;
      p3_cz    <= p2_cz;
      p3_pz    <= p2_pz;
    end
  end

  // Stage 4: round the product, shift the dividends and check quotient range.
  step_t       st [0:NSTEP];
  step_t       s0_nx;
  logic [63:0] mr_re, mr_im;
  logic [32:0] ms_re, ms_im;
  logic [RW-1:0] n_re, n_im, den_top;

  assign mr_re   = (p3_mm_re >> FRAC_BITS) + 64'(p3_mm_re[FRAC_BITS-1]);
  assign mr_im   = (p3_mm_im >> FRAC_BITS) + 64'(p3_mm_im[FRAC_BITS-1]);
  assign ms_re   = sat_mag(p3_mn_re, mr_re);
  assign ms_im   = sat_mag(p3_mn_im, mr_im);
  assign n_re    = RW'(p3_dm_re) << FRAC_BITS;
  assign n_im    = RW'(p3_dm_im) << FRAC_BITS;
  assign den_top = RW'(p3_den) << QB;

  always_comb begin
    s0_nx.vld     = p3_vld;
    s0_nx.cmd     = p3_cmd;
    s0_nx.e_re    = p3_e_re;
    s0_nx.e_im    = p3_e_im;
    s0_nx.e_sat   = p3_e_sat;
    if (p3_cmd == CMD_MUL) begin
      s0_nx.e_re  = ms_re[31:0];
      s0_nx.e_im  = ms_im[31:0];
      s0_nx.e_sat = ms_re[32] | ms_im[32];
    end
    s0_nx.eq      = p3_eq;
    s0_nx.den     = p3_den;
    s0_nx.dre_neg = p3_dn_re;
    s0_nx.dim_neg = p3_dn_im;
    s0_nx.dre_ovf = (n_re >= den_top);
    s0_nx.dim_ovf = (n_im >= den_top);
    s0_nx.dre_r   = n_re;
    s0_nx.dim_r   = n_im;
    s0_nx.dre_q   = '0;
    s0_nx.dim_q   = '0;
    s0_nx.sq_n    = p3_sq;
    s0_nx.sq_r    = '0;
    s0_nx.cx      = p3_cx;
    s0_nx.cy      = p3_cy;
    s0_nx.cz      = p3_cz;
    s0_nx.pzero   = p3_pz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (adv) begin
      st[0] <= s0_nx;
    end
  end

  // Iterative stages.
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    cau_step #(
      .J             (i),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_step (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .d   (st[i]),
      .q   (st[i+1])
    );
  end

  // Final stage: round quotient, root and angle, then pick the result.
  step_t                f;
  logic                 rq_re, rq_im;
  logic [QB:0]          q_re, q_im;
  logic [32:0]          dv_re, dv_im, sqv, phv;
  logic [32:0]          sq_fin;
  logic signed [ZW-1:0] zf, zr;
  logic [31:0]          re_nx, im_nx;
  logic                 eq_nx, sat_nx, div0_nx;
  logic [1:0]           st_nx;

  assign f      = st[NSTEP];
  assign rq_re  = {f.dre_r, 1'b0} >= (RW+1)'(f.den);
  assign rq_im  = {f.dim_r, 1'b0} >= (RW+1)'(f.den);
  assign q_re   = {1'b0, f.dre_q} + (QB+1)'(rq_re);
  assign q_im   = {1'b0, f.dim_q} + (QB+1)'(rq_im);
  assign dv_re  = f.dre_ovf ? {1'b1, (f.dre_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)}
                            : sat_mag(f.dre_neg, 64'(q_re));
  assign dv_im  = f.dim_ovf ? {1'b1, (f.dim_neg ? 32'h8000_0000 : 32'h7FFF_FFFF)}
                            : sat_mag(f.dim_neg, 64'(q_im));
  assign sq_fin = f.sq_r[32:0] + 33'(f.sq_n > f.sq_r);
  assign sqv    = sat_mag(1'b0, 64'(sq_fin));
  assign zf     = f.pzero ? '0 : f.cz;
  assign zr     = (zf + ZRND) >>> SH;
  assign phv    = sat_s34(zr);

  always_comb begin
    re_nx   = '0;
    im_nx   = '0;
    eq_nx   = 1'b0;
    sat_nx  = 1'b0;
    div0_nx = 1'b0;
    case (f.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL: begin
        re_nx  = f.e_re;
        im_nx  = f.e_im;
        sat_nx = f.e_sat;
      end
      CMD_DIV: begin
        if (f.den == 64'd0) begin
          div0_nx = 1'b1;
        end else begin
          re_nx  = dv_re[31:0];
          im_nx  = dv_im[31:0];
          sat_nx = dv_re[32] | dv_im[32];
        end
      end
      CMD_MAG: begin
        re_nx  = sqv[31:0];
        sat_nx = sqv[32];
      end
      CMD_PHASE: begin
        re_nx  = phv[31:0];
        sat_nx = phv[32];
      end
      CMD_EQ: begin
        eq_nx = f.eq;
      end
      default: begin
        re_nx = '0;
      end
    endcase
    st_nx = div0_nx ? ST_DIV0 : (sat_nx ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= f.vld;
      res_re    <= re_nx;
      res_im    <= im_nx;
      is_equal  <= eq_nx;
      status    <= st_nx;
    end
  end

endmodule

/* rtl/cau_chk.sv */
// Port-level checks of the complex arithmetic unit, bound to its top level.
module cau_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_re,
  input logic [31:0] res_im,
  input logic        is_equal,
  input logic [1:0]  status
);
  import cau_pkg::*;

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // With an empty output register the unit must take input.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input refused while output register empty");

  // A zero divisor yields an all-zero result.
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_DIV0 |-> res_re == 32'd0 && res_im == 32'd0 && !is_equal)
    else $error("divide by zero result not cleared");

  // An equality hit carries no numeric result and no error.
  a_eq_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_equal |-> res_re == 32'd0 && res_im == 32'd0 && status == ST_OK)
    else $error("equality result carries stray data");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind complex_arithmetic_unit_top cau_chk u_cau_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res_re    (res_re),
  .res_im    (res_im),
  .is_equal  (is_equal),
  .status    (status)
);

/* tb/sv/complex_arithmetic_unit_top_test.sv */
// Self-checking testbench for the pipelined complex arithmetic unit.
module complex_arithmetic_unit_top_test;
  import cau_pkg::*;

  // Command code that the unit does not define; it must give an all-zero result.
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // Cycles without any accepted word before the run is declared hung.
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 100;
  localparam logic signed [31:0] MAX_S = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_S = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;

  // One result word of the unit.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               eq;
    logic [1:0]         st;
  } cres_t;

  // One row of the directed stimulus table. When known is set, the result is
  // typed into the row; otherwise the predictor supplies it.
  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] ar, ai, br, bi;
    bit                 known;
    cres_t              want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         command = CMD_ADD;
  logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] res_re, res_im;
  logic               is_equal;
  logic [1:0]         status;

  cres_t pending_q[$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    recv_hold = 0;
  int    quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  complex_arithmetic_unit_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_re(res_re), .res_im(res_im), .is_equal(is_equal), .status(status)
  );

  // Arctangent of 2^-i with 30 fractional bits, the CORDIC rotation angles.
  function automatic longint cordic_angle(input int i);
    longint angles [0:10];
    angles = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
               16775851, 8388437, 4194283, 2097149, 1048576};
    if (i < 11) return angles[i];
    return longint'(1) <<< (ANG_BITS - i);
  endfunction

  // Clamp to 32 bits; bit 32 flags that clamping happened.
  function automatic logic [32:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return {1'b1, MAX_S};
    if (v < -128'sd2147483648) return {1'b1, MIN_S};
    return {1'b0, v[31:0]};
  endfunction

  // Rounded product part: exact sum of two products, rounded half away from zero.
  function automatic logic signed [127:0] prod_round(input logic signed [127:0] s);
    logic [127:0] m;
    logic [127:0] r;
    m = (s < 0) ? -s : s;
    r = (m >> FRAC_BITS_DEF) + 128'(m[FRAC_BITS_DEF-1]);
    return (s < 0) ? -$signed(r) : $signed(r);
  endfunction

  // Rounded quotient part: numerator scaled up by the fraction bits.
  function automatic logic signed [127:0] quot_round(input logic signed [127:0] s,
                                                     input logic [127:0] den);
    logic [127:0] m;
    logic [127:0] q;
    logic [127:0] r;
    m = ((s < 0) ? -s : s) << FRAC_BITS_DEF;
    q = m / den;
    r = m % den;
    if (r >= den - r) q = q + 128'd1;
    return (s < 0) ? -$signed(q) : $signed(q);
  endfunction

  // Square root rounded to nearest by the digit-by-digit method.
  function automatic logic [63:0] root_round(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > res) res = res + 64'd1;
    return res;
  endfunction

  // Vectoring CORDIC angle of (re, im) with 30 fractional bits.
  function automatic longint angle_q30(input logic signed [31:0] re,
                                       input logic signed [31:0] im);
    longint x, y, z, t, xs, ys;
    x = longint'(re) * (longint'(1) <<< 29);
    y = longint'(im) * (longint'(1) <<< 29);
    z = 0;
    if (re == 0 && im == 0) return 0;
    // Left half plane: rotate by a quarter turn first.
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(PI_HALF);
      end else begin
        x = -y; y = t; z = -longint'(PI_HALF);
      end
    end
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += cordic_angle(i);
      end else begin
        x -= ys; y += xs; z -= cordic_angle(i);
      end
    end
    return z;
  endfunction

  // Expected result word for one command and operand set.
  function automatic cres_t predict_result(input logic [2:0] cmd,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi);
    cres_t r;
    logic [32:0] cr, ci;
    logic signed [127:0] par, pai, pbr, pbi;
    logic [127:0] den;
    logic [63:0] root;
    longint z;
    r = '0;
    cr = '0;
    ci = '0;
    par = 128'(ar); pai = 128'(ai); pbr = 128'(br); pbi = 128'(bi);
    case (cmd)
      CMD_ADD: begin
        cr = clamp32(par + pbr); ci = clamp32(pai + pbi);
      end
      CMD_SUB: begin
        cr = clamp32(par - pbr); ci = clamp32(pai - pbi);
      end
      CMD_MUL: begin
        cr = clamp32(prod_round(par * pbr - pai * pbi));
        ci = clamp32(prod_round(par * pbi + pai * pbr));
      end
      CMD_DIV: begin
        den = pbr * pbr + pbi * pbi;
        if (den != 0) begin
          cr = clamp32(quot_round(par * pbr + pai * pbi, den));
          ci = clamp32(quot_round(pai * pbr - par * pbi, den));
        end
      end
      CMD_MAG: begin
        root = root_round(64'(par * par + pai * pai));
        cr = (root > 64'h7FFF_FFFF) ? {1'b1, MAX_S} : {1'b0, root[31:0]};
      end
      CMD_PHASE: begin
        z = angle_q30(ar, ai);
        z = (z + (longint'(1) <<< (ANG_BITS - FRAC_BITS_DEF - 1)))
            >>> (ANG_BITS - FRAC_BITS_DEF);
        cr = clamp32(128'(z));
      end
      CMD_EQ: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    r.re = cr[31:0];
    r.im = ci[31:0];
    if (cmd == CMD_DIV && br == 0 && bi == 0) r.st = ST_DIV0;
    else if (cr[32] || ci[32]) r.st = ST_SAT;
    else r.st = ST_OK;
    return r;
  endfunction

  function automatic row_t mk_row(input logic [2:0] cmd,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi,
      input bit known, input cres_t want);
    row_t w;
    w.cmd = cmd; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    w.known = known; w.want = want;
    return w;
  endfunction

  // Random operand part: wide values, small fixed-point values and the extremes.
  function automatic logic signed [31:0] pick_part();
    logic signed [31:0] corner [0:5];
    corner = '{MAX_S, MIN_S, 32'sd0, -32'sd1, 32'sd1, ONE_Q};
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      2: return corner[$urandom_range(5)];
      default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // Offer one word and wait until the unit takes it; the expectation is queued on
  // acceptance. The sender may idle first, as the current idling mix asks.
  task automatic offer_word(input logic [2:0] cmd,
      input logic signed [31:0] ar, input logic signed [31:0] ai,
      input logic signed [31:0] br, input logic signed [31:0] bi,
      input cres_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(want);
  endtask

  task automatic offer_random(input int count);
    logic [2:0] cmd;
    logic signed [31:0] ar, ai, br, bi;
    for (int n = 0; n < count; n++) begin
      cmd = 3'($urandom_range(7));
      ar = pick_part(); ai = pick_part(); br = pick_part(); bi = pick_part();
      // Bias the special cases: equal operands for the test, zero divisors now and then.
      if (cmd == CMD_EQ && $urandom_range(1)) begin
        br = ar;
        if ($urandom_range(1)) bi = ai;
      end
      if (cmd == CMD_DIV && $urandom_range(9) == 0) begin
        br = 0; bi = 0;
      end
      offer_word(cmd, ar, ai, br, bi, predict_result(cmd, ar, ai, br, bi));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Result side: check each accepted word against the oldest expectation, then
  // choose the next ready value. A long hold, when requested, is counted here.
  always @(posedge clk) begin
    cres_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result re=%h im=%h eq=%b st=%0d", $time,
                   res_re, res_im, is_equal, status);
        end else begin
          want = pending_q.pop_front();
          if (res_re !== want.re) begin
            errors++;
            $display("%0t: res_re expected %h actual %h", $time, want.re, res_re);
          end
          if (res_im !== want.im) begin
            errors++;
            $display("%0t: res_im expected %h actual %h", $time, want.im, res_im);
          end
          if (is_equal !== want.eq) begin
            errors++;
            $display("%0t: is_equal expected %b actual %b", $time, want.eq, is_equal);
          end
          if (status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold <= recv_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a long run of cycles in which neither side moves a word means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    row_t  rows[$];
    cres_t none;
    none = '0;
    // Directed table: saturating extremes, the divide-by-zero and zero-angle cases,
    // equality, the unused command, and ordinary words of add, multiply, divide and magnitude.
    rows.push_back(mk_row(CMD_ADD, MAX_S, MIN_S, 32'sd1, -32'sd1, 1,
                          '{re: MAX_S, im: MIN_S, eq: 1'b0, st: ST_SAT}));
    rows.push_back(mk_row(CMD_ADD, ONE_Q, ONE_Q, ONE_Q, -ONE_Q, 1,
                          '{re: 32'sh0002_0000, im: 32'sd0, eq: 1'b0, st: ST_OK}));
    rows.push_back(mk_row(CMD_SUB, MIN_S, MAX_S, 32'sd1, -32'sd1, 1,
                          '{re: MIN_S, im: MAX_S, eq: 1'b0, st: ST_SAT}));
    rows.push_back(mk_row(CMD_MUL, ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1,
                          '{re: 32'sd0, im: 32'sh0002_0000, eq: 1'b0, st: ST_OK}));
    rows.push_back(mk_row(CMD_MUL, MIN_S, MIN_S, MIN_S, MIN_S, 0, none));
    rows.push_back(mk_row(CMD_MUL, MAX_S, MIN_S, MIN_S, MAX_S, 0, none));
    rows.push_back(mk_row(CMD_MUL, 32'sd3, -32'sd5, 32'sh0000_8000, 32'sd7, 0, none));
    rows.push_back(mk_row(CMD_DIV, MAX_S, MIN_S, 32'sd0, 32'sd0, 1,
                          '{re: 32'sd0, im: 32'sd0, eq: 1'b0, st: ST_DIV0}));
    rows.push_back(mk_row(CMD_DIV, ONE_Q, 32'sd0, ONE_Q, 32'sd0, 1,
                          '{re: ONE_Q, im: 32'sd0, eq: 1'b0, st: ST_OK}));
    rows.push_back(mk_row(CMD_DIV, MAX_S, MAX_S, 32'sd1, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_DIV, MIN_S, MIN_S, MIN_S, MAX_S, 0, none));
    rows.push_back(mk_row(CMD_DIV, 32'sd1, -32'sd1, 32'sd3, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_MAG, 32'sd0, 32'sd0, MAX_S, MIN_S, 1, none));
    rows.push_back(mk_row(CMD_MAG, MIN_S, MIN_S, 32'sd0, 32'sd0, 1,
                          '{re: MAX_S, im: 32'sd0, eq: 1'b0, st: ST_SAT}));
    rows.push_back(mk_row(CMD_MAG, 32'sh0003_0000, -32'sh0004_0000, 32'sd0, 32'sd0, 1,
                          '{re: 32'sh0005_0000, im: 32'sd0, eq: 1'b0, st: ST_OK}));
    rows.push_back(mk_row(CMD_PHASE, 32'sd0, 32'sd0, ONE_Q, ONE_Q, 1, none));
    rows.push_back(mk_row(CMD_PHASE, MIN_S, 32'sd0, 32'sd0, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_PHASE, MIN_S, -32'sd1, 32'sd0, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_PHASE, 32'sd0, MIN_S, 32'sd0, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_PHASE, MAX_S, MAX_S, 32'sd0, 32'sd0, 0, none));
    rows.push_back(mk_row(CMD_EQ, MIN_S, MAX_S, MIN_S, MAX_S, 1,
                          '{re: 32'sd0, im: 32'sd0, eq: 1'b1, st: ST_OK}));
    rows.push_back(mk_row(CMD_EQ, MIN_S, MAX_S, MIN_S, MIN_S, 1, none));
    rows.push_back(mk_row(CMD_UNUSED, MAX_S, MAX_S, MAX_S, MAX_S, 1, none));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) begin
      offer_word(rows[k].cmd, rows[k].ar, rows[k].ai, rows[k].br, rows[k].bi,
                 rows[k].known ? rows[k].want
                               : predict_result(rows[k].cmd, rows[k].ar, rows[k].ai,
                                                rows[k].br, rows[k].bi));
    end

    // Sender mostly active, receiver mostly idle.
    send_idle_pct = 29;
    recv_idle_pct = 68;
    offer_random(560);

    // Sender mostly idle, receiver mostly active.
    send_idle_pct = 68;
    recv_idle_pct = 29;
    offer_random(560);

    // Back pressure: the receiver holds off for a long stretch while words keep
    // coming, so the pipeline fills and must drop in_ready.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 300;
    offer_random(60);

    // The sender pauses until every outstanding result has come back.
    wait_drained();

    // Neither side idles.
    offer_random(520);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
